@@ hdl/mmcmap_pkg.sv @@
// Shared types, codes and constants of the multicart bank mapper.
`timescale 1ns / 1ps
`default_nettype none
package mmcmap_pkg;

	typedef enum logic [1:0] {
		OP_CPU_WR = 2'd0,
		OP_TICK   = 2'd1,
		OP_CPU_RD = 2'd2,
		OP_PPU_RD = 2'd3
	} op_t;

	// configuration register indexes
	localparam logic [1:0] CFG_ALT_OUTER   = 2'd0;
	localparam logic [1:0] CFG_FOUR_SCREEN = 2'd1;
	localparam logic [1:0] CFG_HAS_CHR     = 2'd2;

	// CPU register map (address masked by REG_DECODE_MASK)
	localparam logic [15:0] ADDR_OUTER_LOW  = 16'h6000;
	localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
	localparam logic [15:0] REG_BANK_SEL    = 16'h8000;
	localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
	localparam logic [15:0] REG_MIRROR      = 16'hA000;
	localparam logic [15:0] REG_OUTER       = 16'hA001;
	localparam logic [15:0] REG_IRQ_COUNT   = 16'hC000;
	localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
	localparam logic [15:0] REG_IRQ_OFF     = 16'hE000;
	localparam logic [15:0] REG_IRQ_ON      = 16'hE001;

	localparam logic [2:0] OUTER_BIG     = 3'd6;
	localparam logic [2:0] OUTER_ILLEGAL = 3'd7;
	localparam logic [8:0] LAST_VISIBLE  = 9'd239;
	localparam logic [15:0] CHR_LIMIT    = 16'h2000;

	// bank RAM entries: 0..5 CHR banks, 6..7 PRG banks (matches selector code)
	localparam int unsigned BANK_ENTRIES = 8;
	localparam logic [2:0] BANK_PRG0 = 3'd6;
	localparam logic [2:0] BANK_PRG1 = 3'd7;

	typedef logic [2:0] bank_idx_t;

	function automatic logic [7:0] bank_reset_value(input bank_idx_t idx);
		logic [7:0] v;
		v = 8'd0;
		case (idx)
			3'd0: v = 8'd0;
			3'd1: v = 8'd2;
			3'd2: v = 8'd4;
			3'd3: v = 8'd5;
			3'd4: v = 8'd6;
			3'd5: v = 8'd7;
			3'd6: v = 8'd0;
			3'd7: v = 8'd1;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

	// mapper state seen by the translate stage
	typedef struct packed {
		logic [7:0] bank_select;
		logic [2:0] outer_bank;
		logic       has_chr_rom;
	} map_ctx_t;

	// state update outcome of one transaction
	typedef struct packed {
		logic irq_pending;
		logic mirror_state;
	} map_flags_t;

	typedef struct packed {
		logic       en;
		bank_idx_t  addr;
		logic [7:0] data;
	} bank_wr_t;

	typedef struct packed {
		op_t        op;
		logic [15:0] address;
		map_ctx_t   ctx;
		map_flags_t flags;
	} xlate_s1_t;

	typedef struct packed {
		logic [19:0] rom_address;
		logic        irq_line;
		logic        mirror_horizontal;
	} result_t;

	// bank RAM entry that a translation needs
	function automatic bank_idx_t bank_read_index(input op_t op, input logic [15:0] address,
			input logic [7:0] bank_select);
		logic [2:0] slot;
		bank_idx_t  idx;
		slot = 3'd0;
		idx  = BANK_PRG0;
		if (op == OP_PPU_RD) begin
			slot = address[12:10] ^ {bank_select[7], 2'b00};
			if (slot[2])
				idx = slot - 3'd2;
			else
				idx = {2'b00, slot[1]};
		end else begin
			idx = (address[14:13] == 2'd1) ? BANK_PRG1 : BANK_PRG0;
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

@@ hdl/mmcmap_if.sv @@
// Channel interfaces: item input, result output and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface mmcmap_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic [8:0]  scanline;
	logic        display_on;

	modport source (output valid, opcode, address, write_data, scanline, display_on,
		input ready);
	modport sink (input valid, opcode, address, write_data, scanline, display_on,
		output ready);
endinterface

interface mmcmap_result_if;
	logic        valid;
	logic        ready;
	logic [19:0] rom_address;
	logic        irq_line;
	logic        mirror_horizontal;

	modport source (output valid, rom_address, irq_line, mirror_horizontal, input ready);
	modport sink (input valid, rom_address, irq_line, mirror_horizontal, output ready);
endinterface

interface mmcmap_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/mmcmap_bank_ram.sv @@
// Bank register RAM: 8 x 8, one write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mmcmap_bank_ram (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mmcmap_pkg::bank_wr_t  wr,
	input  wire logic                  rd_en,
	input  wire mmcmap_pkg::bank_idx_t rd_addr,
	output logic [7:0]                 rd_data
);

	logic [7:0] mem [mmcmap_pkg::BANK_ENTRIES];
	logic [mmcmap_pkg::BANK_ENTRIES-1:0] vld_q;
	logic [7:0]             rdata_q;
	logic                   rvld_q;
	mmcmap_pkg::bank_idx_t  raddr_q;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
	end

	// entries never written read back their power-on bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			rvld_q  <= vld_q[rd_addr];
			raddr_q <= rd_addr;
		end
	end

	assign rd_data = rvld_q ? rdata_q : mmcmap_pkg::bank_reset_value(raddr_q);

endmodule
`default_nettype wire

@@ hdl/mmcmap_regs.sv @@
// Control state: bank select, outer bank, IRQ counter, mirroring, config.
`timescale 1ns / 1ps
`default_nettype none
module mmcmap_regs (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire mmcmap_pkg::op_t         op,
	input  wire logic [15:0]             address,
	input  wire logic [7:0]              write_data,
	input  wire logic [8:0]              scanline,
	input  wire logic                    display_on,
	input  wire logic                    cfg_we,
	input  wire logic [1:0]              cfg_index,
	input  wire logic                    cfg_data,
	output mmcmap_pkg::map_ctx_t         ctx,
	output mmcmap_pkg::map_flags_t       flags_next,
	output mmcmap_pkg::bank_wr_t         bank_wr
);

	logic       alt_outer_q, four_screen_q, has_chr_q;
	logic [7:0] bank_select_q, bank_select_d;
	logic [2:0] outer_q, outer_d;
	logic [7:0] irq_count_q, irq_count_d, irq_dec;
	logic [7:0] irq_reload_q, irq_reload_d;
	logic       irq_en_q, irq_en_d;
	logic       irq_pend_q, irq_pend_d;
	logic       mirror_q, mirror_d;

	always_comb begin
		bank_select_d = bank_select_q;
		outer_d       = outer_q;
		irq_count_d   = irq_count_q;
		irq_reload_d  = irq_reload_q;
		irq_en_d      = irq_en_q;
		irq_pend_d    = irq_pend_q;
		mirror_d      = mirror_q;
		bank_wr       = '{en: 1'b0, addr: bank_select_q[2:0], data: write_data};
		irq_dec       = irq_count_q - 8'd1;

		if (op == mmcmap_pkg::OP_CPU_WR) begin
			if (address == mmcmap_pkg::ADDR_OUTER_LOW) begin
				outer_d = alt_outer_q ? {1'b0, write_data[2:1]} : {1'b0, write_data[0], 1'b0};
			end else if (address[15]) begin
				unique case (address & mmcmap_pkg::REG_DECODE_MASK)
					mmcmap_pkg::REG_BANK_SEL: bank_select_d = write_data;
					mmcmap_pkg::REG_BANK_DATA: begin
						bank_wr.en = 1'b1;
						// 2 KiB CHR slots ignore the low bank bit
						if (bank_select_q[2:1] == 2'b00)
							bank_wr.data = {write_data[7:1], 1'b0};
					end
					mmcmap_pkg::REG_MIRROR: begin
						if (!four_screen_q)
							mirror_d = write_data[0];
					end
					mmcmap_pkg::REG_OUTER: begin
						outer_d = (write_data[2:0] == mmcmap_pkg::OUTER_ILLEGAL) ?
							mmcmap_pkg::OUTER_BIG : write_data[2:0];
					end
					mmcmap_pkg::REG_IRQ_COUNT: irq_count_d = write_data;
					mmcmap_pkg::REG_IRQ_RELOAD: irq_reload_d = write_data;
					mmcmap_pkg::REG_IRQ_OFF: begin
						irq_en_d   = 1'b0;
						irq_pend_d = 1'b0;
					end
					mmcmap_pkg::REG_IRQ_ON: irq_en_d = 1'b1;
					default: ;
				endcase
			end
		end else if (op == mmcmap_pkg::OP_TICK) begin
			if (scanline <= mmcmap_pkg::LAST_VISIBLE && display_on && irq_en_q) begin
				if (irq_dec == 8'd0) begin
					irq_count_d = irq_reload_q;
					irq_pend_d  = 1'b1;
				end else begin
					irq_count_d = irq_dec;
				end
			end
		end

		if (!accept)
			bank_wr.en = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_select_q <= '0;
			outer_q       <= '0;
			irq_count_q   <= '0;
			irq_reload_q  <= '0;
			irq_en_q      <= 1'b0;
			irq_pend_q    <= 1'b0;
			mirror_q      <= 1'b0;
		end else if (accept) begin
			bank_select_q <= bank_select_d;
			outer_q       <= outer_d;
			irq_count_q   <= irq_count_d;
			irq_reload_q  <= irq_reload_d;
			irq_en_q      <= irq_en_d;
			irq_pend_q    <= irq_pend_d;
			mirror_q      <= mirror_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_outer_q   <= 1'b0;
			four_screen_q <= 1'b0;
			has_chr_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mmcmap_pkg::CFG_ALT_OUTER:   alt_outer_q   <= cfg_data;
				mmcmap_pkg::CFG_FOUR_SCREEN: four_screen_q <= cfg_data;
				mmcmap_pkg::CFG_HAS_CHR:     has_chr_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ctx        = '{bank_select: bank_select_q, outer_bank: outer_q,
		has_chr_rom: has_chr_q};
	assign flags_next = '{irq_pending: irq_pend_d, mirror_state: mirror_d};

endmodule
`default_nettype wire

@@ hdl/mmcmap_xlate.sv @@
// Translate stage: forms the PRG or CHR ROM address from the bank RAM word.
`timescale 1ns / 1ps
`default_nettype none
module mmcmap_xlate (
	input  wire mmcmap_pkg::xlate_s1_t s1,
	input  wire logic [7:0]            bank,
	output mmcmap_pkg::result_t        res
);

	logic       big;
	logic       swap;
	logic [4:0] prg_mask, prg_second_last, prg_bank;
	logic [6:0] prg_full;
	logic [2:0] chr_slot;
	logic [7:0] chr_bank, chr_mask;
	logic [9:0] chr_full;
	logic [19:0] rom;

	always_comb begin
		big             = (s1.ctx.outer_bank == mmcmap_pkg::OUTER_BIG);
		swap            = s1.ctx.bank_select[6];
		prg_mask        = big ? 5'h1F : 5'h0F;
		prg_second_last = big ? 5'h1E : 5'h0E;
		case (s1.address[14:13])
			2'd0:    prg_bank = swap ? prg_second_last : (bank[4:0] & prg_mask);
			2'd1:    prg_bank = bank[4:0] & prg_mask;
			2'd2:    prg_bank = swap ? (bank[4:0] & prg_mask) : prg_second_last;
			default: prg_bank = prg_mask;
		endcase
		prg_full = {2'b00, prg_bank} | {s1.ctx.outer_bank, 4'b0000};

		// odd 1 KiB half of a 2 KiB slot takes the next bank
		chr_slot = s1.address[12:10] ^ {s1.ctx.bank_select[7], 2'b00};
		chr_bank = (!chr_slot[2] && chr_slot[0]) ? bank + 8'd1 : bank;
		chr_mask = big ? 8'hFF : 8'h7F;
		chr_full = {2'b00, chr_bank & chr_mask} | {s1.ctx.outer_bank, 7'd0};

		rom = '0;
		case (s1.op)
			mmcmap_pkg::OP_CPU_RD: begin
				if (s1.address[15])
					rom = {prg_full, s1.address[12:0]};
			end
			mmcmap_pkg::OP_PPU_RD: begin
				if (!s1.ctx.has_chr_rom)
					rom = {4'd0, s1.address};
				else if (s1.address < mmcmap_pkg::CHR_LIMIT)
					rom = {chr_full, s1.address[9:0]};
			end
			default: rom = '0;
		endcase

		res = '{rom_address: rom, irq_line: s1.flags.irq_pending,
			mirror_horizontal: s1.flags.mirror_state};
	end

endmodule
`default_nettype wire

@@ hdl/multicart_mmc3_bank_mapper.sv @@
// Top level: MMC3-style bank mapper with outer game select.
// Accepted transactions are registered in stage 1 with the bank RAM read,
//   then in the output register (one translate stage between). Throughput:
//   one transaction per cycle when results are taken; ready is not decoupled.
// Reset (arst_n low, async): control state, IRQ, mirroring and config return
//   to power-on values; bank RAM reads power-on banks until each is written.
`timescale 1ns / 1ps
`default_nettype none
module multicart_mmc3_bank_mapper (
	input  wire logic         clk,
	input  wire logic         arst_n,
	mmcmap_item_if.sink       item,
	mmcmap_result_if.source   result,
	mmcmap_cfg_if.sink        cfg
);

	// handshake
	logic accept;
	logic advance;
	logic s1_v_q;
	logic res_v_q;

	mmcmap_pkg::map_ctx_t   ctx;
	mmcmap_pkg::map_flags_t flags_next;
	mmcmap_pkg::bank_wr_t   bank_wr;
	mmcmap_pkg::bank_idx_t  rd_idx;
	mmcmap_pkg::op_t        op;
	mmcmap_pkg::xlate_s1_t  s1_s1;
	mmcmap_pkg::result_t    res_comb;
	mmcmap_pkg::result_t    res_q;
	logic [7:0]             bank_rd;

	assign op = mmcmap_pkg::op_t'(item.opcode);

	// output register frees when empty or taken; stage 1 advances with it
	assign advance    = !res_v_q || result.ready;
	assign item.ready = !s1_v_q || advance;
	assign accept     = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	// State update happens at acceptance. Every accepted transaction reads the
	// bank RAM at that edge; a bank data register write also writes it there.
	// A write is in the RAM once its edge is past, so no read can overlap it:
	// a translation right after a bank write sees the new word.
	mmcmap_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (op),
		.address    (item.address),
		.write_data (item.write_data),
		.scanline   (item.scanline),
		.display_on (item.display_on),
		.cfg_we     (cfg.valid && cfg.ready),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.ctx        (ctx),
		.flags_next (flags_next),
		.bank_wr    (bank_wr)
	);

	assign rd_idx = mmcmap_pkg::bank_read_index(op, item.address, ctx.bank_select);

	mmcmap_bank_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (bank_wr),
		.rd_en   (accept),
		.rd_addr (rd_idx),
		.rd_data (bank_rd)
	);

	// stage 1: snapshot of context; translate ops leave it unchanged
	always_ff @(posedge clk) begin
		if (accept)
			s1_s1 <= '{op: op, address: item.address, ctx: ctx, flags: flags_next};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (accept) begin
			s1_v_q <= 1'b1;
		end else if (advance) begin
			s1_v_q <= 1'b0;
		end
	end

	mmcmap_xlate u_xlate (
		.s1   (s1_s1),
		.bank (bank_rd),
		.res  (res_comb)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (advance) begin
			res_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_v_q)
			res_q <= res_comb;
	end

	assign result.valid             = res_v_q;
	assign result.rom_address       = res_q.rom_address;
	assign result.irq_line          = res_q.irq_line;
	assign result.mirror_horizontal = res_q.mirror_horizontal;

endmodule
`default_nettype wire

@@ hdl/mmcmap_checker.sv @@
// Port-level checker for the bank mapper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mmcmap_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [19:0] res_rom_address,
	input wire logic        res_irq_line,
	input wire logic        res_mirror
);

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_rom_address) && $stable(res_irq_line)
			&& $stable(res_mirror))
		else $error("result payload changed while stalled");

	// a fresh result must trace back to an accepted input transaction
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(item_valid && item_ready, 2))
		else $error("result without matching input transaction");

	// input back-pressure only when the output is full and stalled
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(item_ready) |-> res_valid && !res_ready)
		else $error("input stalled without output back-pressure");

endmodule

bind multicart_mmc3_bank_mapper mmcmap_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_valid      (item.valid),
	.item_ready      (item.ready),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.res_rom_address (result.rom_address),
	.res_irq_line    (result.irq_line),
	.res_mirror      (result.mirror_horizontal)
);
`default_nettype wire
